// ===== design/grwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_pkg
// Shared sizes, constants and types for the grid region wall counter.
// ----------------------------------------------------------------------------
package grwc_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int PTR_W    = ADDR_W + 1;
  localparam int EXT_W    = 7;
  localparam int CNT_W    = 14;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Memory requests from the labeling engine
  typedef struct packed {
    logic [ADDR_W-1:0] wall_raddr;
    logic [ADDR_W-1:0] vis_raddr;
    logic              vis_we;
    logic [ADDR_W-1:0] vis_waddr;
    logic              vis_wdata;
    logic [ADDR_W-1:0] list_raddr;
    logic              list_we;
    logic [ADDR_W-1:0] list_waddr;
    logic [ADDR_W-1:0] list_wdata;
    logic              ans_we;
    logic [ADDR_W-1:0] ans_waddr;
    logic [CNT_W-1:0]  ans_wdata;
  } lbl_mem_t;

  // Read data returned to the labeling engine
  typedef struct packed {
    logic              wall;
    logic              vis;
    logic [ADDR_W-1:0] list;
  } lbl_rd_t;

endpackage

// ===== design/grid_region_wall_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_region_wall_counter_top
// Grid region wall counter: cell loads, region labeling and count queries.
// ----------------------------------------------------------------------------
// A query has an address cycle, then the result is registered from the answer
// and wall memories. A load marked last starts labeling, during which no item
// is taken: the visited map is cleared, each in-use cell is scanned, the fill
// does one list read per open cell, then a read and an evaluate for each
// in-grid neighbor through the single read port of each memory, and each open
// cell's answer is written. After reset a pass zeroes the answer memory before
// the first item is taken; configuration writes are taken at any time.
module grid_region_wall_counter_top
  import grwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [EXT_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [COL_W-1:0] col_i,
  input  logic             cell_is_wall_i,
  input  logic             last_cell_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CNT_W-1:0] wall_count_o
);

  typedef enum logic [3:0] {
    T_INIT = 4'b0001,
    T_IDLE = 4'b0010,
    T_QRY  = 4'b0100,
    T_LBL  = 4'b1000
  } top_state_e;

  top_state_e        state_q, state_d;
  logic [ADDR_W-1:0] init_q;
  logic [EXT_W-1:0]  rows_q, cols_q;
  logic [EXT_W-1:0]  rows_eff, cols_eff;
  logic              qok_q;
  logic              out_valid_q;
  logic [CNT_W-1:0]  out_q;
  logic              in_xfer;
  logic [ADDR_W-1:0] in_addr;

  lbl_mem_t          lbl_mem;
  lbl_rd_t           lbl_rd;
  logic              lbl_idle;

  logic              wall_we;
  logic [ADDR_W-1:0] wall_raddr;
  logic              ans_we;
  logic [ADDR_W-1:0] ans_waddr;
  logic [CNT_W-1:0]  ans_wdata;
  logic [CNT_W-1:0]  ans_rdata;

  // Extents clamped to 1..MAX
  always_comb begin
    rows_eff = rows_q;
    cols_eff = cols_q;
    if (rows_q == '0) rows_eff = EXT_W'(1);
    else if (rows_q > EXT_W'(MAX_ROWS)) rows_eff = EXT_W'(MAX_ROWS);
    if (cols_q == '0) cols_eff = EXT_W'(1);
    else if (cols_q > EXT_W'(MAX_COLS)) cols_eff = EXT_W'(MAX_COLS);
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= EXT_W'(64);
      cols_q <= EXT_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        default:  cols_q <= cfg_data_i;
      endcase
    end
  end

  assign in_addr    = {row_i, col_i};
  assign in_ready_o = (state_q == T_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Control flow
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_INIT: if (init_q == ADDR_W'(CELLS - 1)) state_d = T_IDLE;
      T_IDLE: begin
        if (in_xfer) begin
          if (op_i == OP_QUERY) state_d = T_QRY;
          else if (last_cell_i) state_d = T_LBL;
        end
      end
      T_QRY:   state_d = T_IDLE;
      T_LBL:   if (lbl_idle) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_INIT;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == T_INIT) init_q <= init_q + ADDR_W'(1);
      if (state_q == T_QRY) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Query result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      qok_q <= (EXT_W'(row_i) < rows_eff) && (EXT_W'(col_i) < cols_eff);
    end
    if (state_q == T_QRY) begin
      out_q <= (qok_q && !lbl_rd.wall) ? ans_rdata : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign wall_count_o = out_q;

  // Memory port selection
  assign wall_we    = in_xfer && (op_i == OP_LOAD);
  assign wall_raddr = (state_q == T_IDLE) ? in_addr : lbl_mem.wall_raddr;
  assign ans_we     = (state_q == T_INIT) || lbl_mem.ans_we;
  assign ans_waddr  = (state_q == T_INIT) ? init_q : lbl_mem.ans_waddr;
  assign ans_wdata  = (state_q == T_INIT) ? '0 : lbl_mem.ans_wdata;

  grwc_ram #(.Width(1), .Depth(CELLS)) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wall_we),
    .waddr_i (in_addr),
    .wdata_i (cell_is_wall_i),
    .raddr_i (wall_raddr),
    .rdata_o (lbl_rd.wall)
  );

  grwc_ram #(.Width(1), .Depth(CELLS)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (lbl_mem.vis_we),
    .waddr_i (lbl_mem.vis_waddr),
    .wdata_i (lbl_mem.vis_wdata),
    .raddr_i (lbl_mem.vis_raddr),
    .rdata_o (lbl_rd.vis)
  );

  grwc_ram #(.Width(ADDR_W), .Depth(CELLS)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lbl_mem.list_we),
    .waddr_i (lbl_mem.list_waddr),
    .wdata_i (lbl_mem.list_wdata),
    .raddr_i (lbl_mem.list_raddr),
    .rdata_o (lbl_rd.list)
  );

  grwc_ram #(.Width(CNT_W), .Depth(CELLS)) u_ans_ram (
    .clk_i   (clk_i),
    .we_i    (ans_we),
    .waddr_i (ans_waddr),
    .wdata_i (ans_wdata),
    .raddr_i (in_addr),
    .rdata_o (ans_rdata)
  );

  grwc_label u_label (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer && (op_i == OP_LOAD) && last_cell_i),
    .rows_i  (rows_eff),
    .cols_i  (cols_eff),
    .rd_i    (lbl_rd),
    .mem_o   (lbl_mem),
    .idle_o  (lbl_idle)
  );

  // Checks
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> lbl_idle) else $error("item taken while labeling");
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_QRY) |=> out_valid_q) else $error("query result lost");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_QRY) |-> !(out_valid_q && !$past(out_ready_i)))
    else $error("pending result overwritten");

endmodule

// ===== design/grwc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grwc_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096,
  localparam int AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/grwc_label.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grwc_label
// Region labeling sequencer: clears the visited map, scans the in-use grid,
// runs a breadth-first fill from each unvisited open cell through the visit
// list memory, then writes the region's wall count to every listed cell.
// ----------------------------------------------------------------------------
module grwc_label
  import grwc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [EXT_W-1:0] rows_i,
  input  logic [EXT_W-1:0] cols_i,
  input  lbl_rd_t          rd_i,
  output lbl_mem_t         mem_o,
  output logic             idle_o
);

  typedef enum logic [9:0] {
    L_IDLE = 10'b0000000001,
    L_CLR  = 10'b0000000010,
    L_SRD  = 10'b0000000100,
    L_SCK  = 10'b0000001000,
    L_POP  = 10'b0000010000,
    L_UGET = 10'b0000100000,
    L_NRD  = 10'b0001000000,
    L_NEV  = 10'b0010000000,
    L_WRA  = 10'b0100000000,
    L_ADV  = 10'b1000000000
  } lbl_state_e;

  lbl_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ROW_W-1:0]  sr_q, sr_d;
  logic [COL_W-1:0]  sc_q, sc_d;
  logic [ROW_W-1:0]  ur_q, ur_d;
  logic [COL_W-1:0]  uc_q, uc_d;
  logic [1:0]        dir_q, dir_d;
  logic [ADDR_W-1:0] n_q, n_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [PTR_W-1:0]  k_q, k_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  walls_q, walls_d;

  // Neighbor of the current cell in the current direction
  logic [ROW_W-1:0]  nr;
  logic [COL_W-1:0]  nc;
  logic              n_ok;
  logic              scan_last;

  always_comb begin
    nr   = ur_q;
    nc   = uc_q;
    n_ok = 1'b0;
    unique case (dir_q)
      2'd0: begin
        nr   = ur_q + ROW_W'(1);
        n_ok = (EXT_W'(ur_q) + EXT_W'(1)) < rows_i;
      end
      2'd1: begin
        nc   = uc_q + COL_W'(1);
        n_ok = (EXT_W'(uc_q) + EXT_W'(1)) < cols_i;
      end
      2'd2: begin
        nc   = uc_q - COL_W'(1);
        n_ok = (uc_q != '0);
      end
      default: begin
        nr   = ur_q - ROW_W'(1);
        n_ok = (ur_q != '0);
      end
    endcase
  end

  assign scan_last = ((EXT_W'(sc_q) + EXT_W'(1)) >= cols_i) &&
                     ((EXT_W'(sr_q) + EXT_W'(1)) >= rows_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    sr_d    = sr_q;
    sc_d    = sc_q;
    ur_d    = ur_q;
    uc_d    = uc_q;
    dir_d   = dir_q;
    n_d     = n_q;
    head_d  = head_q;
    tail_d  = tail_q;
    k_d     = k_q;
    pend_d  = pend_q;
    walls_d = walls_q;
    mem_o   = '0;
    mem_o.wall_raddr = {sr_q, sc_q};
    mem_o.vis_raddr  = {sr_q, sc_q};
    mem_o.ans_waddr  = rd_i.list;
    mem_o.ans_wdata  = walls_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          clr_d   = '0;
          state_d = L_CLR;
        end
      end
      L_CLR: begin
        mem_o.vis_we    = 1'b1;
        mem_o.vis_waddr = clr_q;
        mem_o.vis_wdata = 1'b0;
        clr_d           = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(CELLS - 1)) begin
          sr_d    = '0;
          sc_d    = '0;
          state_d = L_SRD;
        end
      end
      L_SRD: begin
        state_d = L_SCK;
      end
      L_SCK: begin
        if (!rd_i.wall && !rd_i.vis) begin
          // new region seeded at the scan cell
          mem_o.vis_we     = 1'b1;
          mem_o.vis_waddr  = {sr_q, sc_q};
          mem_o.vis_wdata  = 1'b1;
          mem_o.list_we    = 1'b1;
          mem_o.list_waddr = '0;
          mem_o.list_wdata = {sr_q, sc_q};
          head_d           = '0;
          tail_d           = PTR_W'(1);
          walls_d          = '0;
          state_d          = L_POP;
        end else begin
          state_d = L_ADV;
        end
      end
      L_POP: begin
        if (head_q < tail_q) begin
          mem_o.list_raddr = head_q[ADDR_W-1:0];
          head_d           = head_q + PTR_W'(1);
          state_d          = L_UGET;
        end else begin
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = L_WRA;
        end
      end
      L_UGET: begin
        ur_d    = rd_i.list[ADDR_W-1 -: ROW_W];
        uc_d    = rd_i.list[COL_W-1:0];
        dir_d   = '0;
        state_d = L_NRD;
      end
      L_NRD: begin
        mem_o.wall_raddr = {nr, nc};
        mem_o.vis_raddr  = {nr, nc};
        n_d              = {nr, nc};
        if (n_ok) begin
          state_d = L_NEV;
        end else if (dir_q == 2'd3) begin
          state_d = L_POP;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      L_NEV: begin
        if (rd_i.wall) begin
          if (walls_q != COUNT_LIMIT) begin
            walls_d = walls_q + CNT_W'(1);
          end
        end else if (!rd_i.vis) begin
          mem_o.vis_we     = 1'b1;
          mem_o.vis_waddr  = n_q;
          mem_o.vis_wdata  = 1'b1;
          mem_o.list_we    = 1'b1;
          mem_o.list_waddr = tail_q[ADDR_W-1:0];
          mem_o.list_wdata = n_q;
          tail_d           = tail_q + PTR_W'(1);
        end
        dir_d   = dir_q + 2'd1;
        state_d = (dir_q == 2'd3) ? L_POP : L_NRD;
      end
      L_WRA: begin
        // stream the visit list out, one answer write a cycle
        mem_o.ans_we     = pend_q;
        mem_o.list_raddr = k_q[ADDR_W-1:0];
        pend_d           = (k_q < tail_q);
        if (k_q < tail_q) begin
          k_d = k_q + PTR_W'(1);
        end else begin
          state_d = L_ADV;
        end
      end
      L_ADV: begin
        if (scan_last) begin
          state_d = L_IDLE;
        end else begin
          if ((EXT_W'(sc_q) + EXT_W'(1)) < cols_i) begin
            sc_d = sc_q + COL_W'(1);
          end else begin
            sc_d = '0;
            sr_d = sr_q + ROW_W'(1);
          end
          state_d = L_SRD;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
      walls_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      walls_q <= walls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q <= clr_d;
    sr_q  <= sr_d;
    sc_q  <= sc_d;
    ur_q  <= ur_d;
    uc_q  <= uc_d;
    dir_q <= dir_d;
    n_q   <= n_d;
  end

  assign idle_o = (state_q == L_IDLE);

  // Checks
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("list head passed tail");
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= PTR_W'(CELLS)) else $error("visit list overflow");
  a_list_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.list_we |-> (mem_o.vis_we && mem_o.vis_wdata &&
                       mem_o.vis_waddr == mem_o.list_wdata))
    else $error("listed cell not marked visited");
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == L_NEV) |-> ($past(state_q) == L_NRD))
    else $error("neighbor evaluated without read");

endmodule
